// ===== rtl/core/mrmp_pkg.sv =====
// shared types, constants and the sequencer microprogram for the matrix power block
package mrmp_pkg;

    localparam int W_DATA       = 31;
    localparam int W_INDEX      = 32;
    localparam int EXP_BITS_DEF = 32;
    localparam int RF_DEPTH     = 24;
    localparam int W_ADDR       = 5;
    localparam int W_PC         = 6;
    localparam int W_MCNT       = $clog2(W_DATA);

    typedef logic [W_DATA-1:0] t_word;
    typedef logic [W_ADDR-1:0] t_addr;
    typedef logic [W_PC-1:0]   t_pc;

    typedef enum logic [3:0] {
        OP_LD0  = 4'd0,
        OP_LD1  = 4'd1,
        OP_LDA  = 4'd2,
        OP_LDB  = 4'd3,
        OP_MUL  = 4'd4,
        OP_ADD  = 4'd5,
        OP_SUB  = 4'd6,
        OP_BRS  = 4'd7,
        OP_BIT  = 4'd8,
        OP_NEXT = 4'd9,
        OP_OUT  = 4'd10
    } t_op;

    typedef struct packed {
        t_op   op;
        t_addr dst;
        t_addr sx;
        t_addr sy;
        t_pc   tgt;
    } t_ins;

    typedef struct packed {
        logic  start;
        t_word x;
        t_word y;
        t_word m;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mul_rsp;

    // register file map
    localparam t_addr R_ZERO = 5'd0;
    localparam t_addr R_ONE  = 5'd1;
    localparam t_addr R_RA   = 5'd2;
    localparam t_addr R_RB   = 5'd3;
    localparam t_addr R_A    = 5'd4;
    localparam t_addr R_B    = 5'd5;
    localparam t_addr R_A2   = 5'd6;
    localparam t_addr R_S1   = 5'd7;
    localparam t_addr R_S2   = 5'd8;
    localparam t_addr R_TWO  = 5'd9;
    localparam t_addr R_T    = 5'd10;
    localparam t_addr R_N00  = 5'd11;
    localparam t_addr R_N01  = 5'd12;
    localparam t_addr R_N10  = 5'd13;
    localparam t_addr R_N11  = 5'd14;
    localparam t_addr R_B00  = 5'd15;
    localparam t_addr R_B01  = 5'd16;
    localparam t_addr R_B10  = 5'd17;
    localparam t_addr R_B11  = 5'd18;
    localparam t_addr R_C00  = 5'd19;
    localparam t_addr R_C01  = 5'd20;
    localparam t_addr R_C10  = 5'd21;
    localparam t_addr R_C11  = 5'd22;
    localparam t_addr R_RES  = 5'd23;

    localparam t_pc PC_LOOP = 6'd21;
    localparam t_pc PC_SQ   = 6'd38;
    localparam t_pc PC_OUT  = 6'd58;

    function automatic t_ins mk(t_op op, t_addr dst, t_addr sx, t_addr sy, t_pc tgt);
        t_ins ins;
        ins.op  = op;
        ins.dst = dst;
        ins.sx  = sx;
        ins.sy  = sy;
        ins.tgt = tgt;
        return ins;
    endfunction

    function automatic t_ins ucode(t_pc pc);
        t_ins ins;
        unique case (pc)
            // operand setup
            6'd0:  ins = mk(OP_LD0, R_ZERO, R_ZERO, R_ZERO, '0);
            6'd1:  ins = mk(OP_LD1, R_ONE,  R_ZERO, R_ZERO, '0);
            6'd2:  ins = mk(OP_LDA, R_RA,   R_ZERO, R_ZERO, '0);
            6'd3:  ins = mk(OP_LDB, R_RB,   R_ZERO, R_ZERO, '0);
            6'd4:  ins = mk(OP_MUL, R_A,    R_ONE,  R_RA,   '0);
            6'd5:  ins = mk(OP_MUL, R_B,    R_ONE,  R_RB,   '0);
            6'd6:  ins = mk(OP_MUL, R_A2,   R_A,    R_A,    '0);
            6'd7:  ins = mk(OP_ADD, R_S1,   R_A,    R_A,    '0);
            6'd8:  ins = mk(OP_ADD, R_T,    R_A2,   R_A2,   '0);
            6'd9:  ins = mk(OP_ADD, R_N00,  R_B,    R_B,    '0);
            6'd10: ins = mk(OP_ADD, R_S2,   R_T,    R_N00,  '0);
            6'd11: ins = mk(OP_ADD, R_TWO,  R_ONE,  R_ONE,  '0);
            6'd12: ins = mk(OP_BRS, R_ZERO, R_ZERO, R_ZERO, PC_OUT);
            // companion matrix and identity
            6'd13: ins = mk(OP_SUB, R_B10,  R_B,    R_A2,   '0);
            6'd14: ins = mk(OP_ADD, R_B00,  R_S1,   R_ZERO, '0);
            6'd15: ins = mk(OP_ADD, R_B01,  R_ONE,  R_ZERO, '0);
            6'd16: ins = mk(OP_ADD, R_B11,  R_ZERO, R_ZERO, '0);
            6'd17: ins = mk(OP_ADD, R_C00,  R_ONE,  R_ZERO, '0);
            6'd18: ins = mk(OP_ADD, R_C01,  R_ZERO, R_ZERO, '0);
            6'd19: ins = mk(OP_ADD, R_C10,  R_ZERO, R_ZERO, '0);
            6'd20: ins = mk(OP_ADD, R_C11,  R_ONE,  R_ZERO, '0);
            // loop head: skip accumulate on a zero exponent bit
            6'd21: ins = mk(OP_BIT, R_ZERO, R_ZERO, R_ZERO, PC_SQ);
            // acc = acc * base
            6'd22: ins = mk(OP_MUL, R_T,    R_C00,  R_B00,  '0);
            6'd23: ins = mk(OP_MUL, R_N00,  R_C01,  R_B10,  '0);
            6'd24: ins = mk(OP_ADD, R_N00,  R_T,    R_N00,  '0);
            6'd25: ins = mk(OP_MUL, R_T,    R_C00,  R_B01,  '0);
            6'd26: ins = mk(OP_MUL, R_N01,  R_C01,  R_B11,  '0);
            6'd27: ins = mk(OP_ADD, R_N01,  R_T,    R_N01,  '0);
            6'd28: ins = mk(OP_MUL, R_T,    R_C10,  R_B00,  '0);
            6'd29: ins = mk(OP_MUL, R_N10,  R_C11,  R_B10,  '0);
            6'd30: ins = mk(OP_ADD, R_N10,  R_T,    R_N10,  '0);
            6'd31: ins = mk(OP_MUL, R_T,    R_C10,  R_B01,  '0);
            6'd32: ins = mk(OP_MUL, R_N11,  R_C11,  R_B11,  '0);
            6'd33: ins = mk(OP_ADD, R_N11,  R_T,    R_N11,  '0);
            6'd34: ins = mk(OP_ADD, R_C00,  R_N00,  R_ZERO, '0);
            6'd35: ins = mk(OP_ADD, R_C01,  R_N01,  R_ZERO, '0);
            6'd36: ins = mk(OP_ADD, R_C10,  R_N10,  R_ZERO, '0);
            6'd37: ins = mk(OP_ADD, R_C11,  R_N11,  R_ZERO, '0);
            // base = base * base
            6'd38: ins = mk(OP_MUL, R_T,    R_B00,  R_B00,  '0);
            6'd39: ins = mk(OP_MUL, R_N00,  R_B01,  R_B10,  '0);
            6'd40: ins = mk(OP_ADD, R_N00,  R_T,    R_N00,  '0);
            6'd41: ins = mk(OP_MUL, R_T,    R_B00,  R_B01,  '0);
            6'd42: ins = mk(OP_MUL, R_N01,  R_B01,  R_B11,  '0);
            6'd43: ins = mk(OP_ADD, R_N01,  R_T,    R_N01,  '0);
            6'd44: ins = mk(OP_MUL, R_T,    R_B10,  R_B00,  '0);
            6'd45: ins = mk(OP_MUL, R_N10,  R_B11,  R_B10,  '0);
            6'd46: ins = mk(OP_ADD, R_N10,  R_T,    R_N10,  '0);
            6'd47: ins = mk(OP_MUL, R_T,    R_B10,  R_B01,  '0);
            6'd48: ins = mk(OP_MUL, R_N11,  R_B11,  R_B11,  '0);
            6'd49: ins = mk(OP_ADD, R_N11,  R_T,    R_N11,  '0);
            6'd50: ins = mk(OP_ADD, R_B00,  R_N00,  R_ZERO, '0);
            6'd51: ins = mk(OP_ADD, R_B01,  R_N01,  R_ZERO, '0);
            6'd52: ins = mk(OP_ADD, R_B10,  R_N10,  R_ZERO, '0);
            6'd53: ins = mk(OP_ADD, R_B11,  R_N11,  R_ZERO, '0);
            6'd54: ins = mk(OP_NEXT, R_ZERO, R_ZERO, R_ZERO, PC_LOOP);
            // s2 * P00 + s1 * P10
            6'd55: ins = mk(OP_MUL, R_T,    R_S2,   R_C00,  '0);
            6'd56: ins = mk(OP_MUL, R_N00,  R_S1,   R_C10,  '0);
            6'd57: ins = mk(OP_ADD, R_RES,  R_T,    R_N00,  '0);
            default: ins = mk(OP_OUT, R_ZERO, R_RES, R_ZERO, '0);
        endcase
        return ins;
    endfunction

endpackage

// ===== rtl/core/mrmp_if.sv =====
// valid/ready channel interfaces for request and result transfers
interface mrmp_in_if;
    import mrmp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [W_DATA-1:0]    coef_a;
    logic [W_DATA-1:0]    coef_b;
    logic [W_INDEX-1:0]   term_index;
    logic [W_DATA-1:0]    modulus;

    modport source (output valid, coef_a, coef_b, term_index, modulus, input ready);
    modport sink   (input valid, coef_a, coef_b, term_index, modulus, output ready);
endinterface

interface mrmp_out_if;
    import mrmp_pkg::*;
    logic              valid;
    logic              ready;
    logic [W_DATA-1:0] term_value;

    modport source (output valid, term_value, input ready);
    modport sink   (input valid, term_value, output ready);
endinterface

// ===== rtl/core/mrmp_modmul.sv =====
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
module mrmp_modmul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrmp_pkg::t_mul_req  i_req,
    output mrmp_pkg::t_mul_rsp  o_rsp
);
    import mrmp_pkg::*;

    logic [W_DATA-1:0] r_acc, n_acc;
    logic [W_DATA-1:0] r_y, n_y;
    logic [W_DATA-1:0] r_x, r_m;
    logic [W_MCNT-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [W_DATA:0]   w_dbl, w_red1, w_sum, w_red2, w_mw;

    always_comb begin
        w_mw   = {1'b0, r_m};
        w_dbl  = {r_acc, 1'b0};
        w_red1 = (w_dbl >= w_mw) ? w_dbl - w_mw : w_dbl;
        w_sum  = w_red1 + (r_y[W_DATA-1] ? {1'b0, r_x} : '0);
        w_red2 = (w_sum >= w_mw) ? w_sum - w_mw : w_sum;
    end

    always_comb begin
        n_acc  = r_acc;
        n_y    = r_y;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_acc  = '0;
            n_y    = i_req.y;
            n_cnt  = W_MCNT'(W_DATA - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = w_red2[W_DATA-1:0];
            n_y   = {r_y[W_DATA-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_y   <= n_y;
        r_cnt <= n_cnt;
        if (i_req.start) begin
            r_x <= i_req.x;
            r_m <= i_req.m;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// ===== rtl/core/modular_recurrence_matrix_power.sv =====
// top level: modular second-order recurrence term by 2x2 matrix power
//
//  channel  | dir | payload                                   | transfer
//  ---------+-----+-------------------------------------------+------------------
//  i_req    | in  | coef_a, coef_b, term_index, modulus       | valid & ready
//  o_rsp    | out | term_value                                | valid & ready
//
// one item at a time: i_req.ready is high only while idle
// index 0..2 skips the matrix power loop; every modular product goes through
// fetch, start and the single bit-serial multiplier, while add and subtract take
// a fetch and an execute step
// a zero modulus answers 0 without running the microprogram, straight from idle
// to the output step; the result holds until o_rsp takes it
// synchronous active-low reset returns the sequencer to idle
module modular_recurrence_matrix_power #(
    parameter int EXP_BITS = mrmp_pkg::EXP_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrmp_in_if.sink    i_req,
    mrmp_out_if.source o_rsp
);
    import mrmp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_EXEC   = 6'b000100,
        S_MSTART = 6'b001000,
        S_MWAIT  = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    t_pc                 r_pc, n_pc;
    t_ins                r_ins, n_ins;
    t_word               r_a_raw, n_a_raw;
    t_word               r_b_raw, n_b_raw;
    t_word               r_m, n_m;
    logic [W_INDEX-1:0]  r_n, n_n;
    logic [EXP_BITS-1:0] r_exp, n_exp;
    logic                r_small, n_small;
    t_word               r_out, n_out;

    // register file, two registered read ports, one write port
    t_word               r_mem [RF_DEPTH];
    t_word               r_rdx, r_rdy;

    t_ins                w_ins;
    t_addr               w_ax;
    logic                w_we;
    t_addr               w_wa;
    t_word               w_wd;
    logic [W_DATA:0]     w_sum, w_addm;
    t_word               w_subm;
    logic [EXP_BITS-1:0] w_exp_shr;
    logic [W_INDEX-1:0]  w_e;
    t_mul_req            w_mreq;
    t_mul_rsp            w_mrsp;

    assign w_ins     = ucode(r_pc);
    assign w_exp_shr = r_exp >> 1;
    assign w_e       = i_req.term_index - W_INDEX'(2);

    // the output step reads the term picked by the index
    always_comb begin
        w_ax = w_ins.sx;
        if (w_ins.op == OP_OUT) begin
            priority if (r_n == W_INDEX'(0)) begin
                w_ax = R_TWO;
            end else if (r_n == W_INDEX'(1)) begin
                w_ax = R_S1;
            end else if (r_n == W_INDEX'(2)) begin
                w_ax = R_S2;
            end else begin
                w_ax = R_RES;
            end
        end
    end

    // modular add and subtract, operands already below the modulus
    always_comb begin
        w_sum  = {1'b0, r_rdx} + {1'b0, r_rdy};
        w_addm = (w_sum >= {1'b0, r_m}) ? w_sum - {1'b0, r_m} : w_sum;
        w_subm = (r_rdx >= r_rdy) ? r_rdx - r_rdy : r_rdx + (r_m - r_rdy);
    end

    always_comb begin
        w_mreq.start = (r_state == S_MSTART);
        w_mreq.x     = r_rdx;
        w_mreq.y     = r_rdy;
        w_mreq.m     = r_m;
    end

    mrmp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_ins   = r_ins;
        n_a_raw = r_a_raw;
        n_b_raw = r_b_raw;
        n_m     = r_m;
        n_n     = r_n;
        n_exp   = r_exp;
        n_small = r_small;
        n_out   = r_out;
        w_we    = 1'b0;
        w_wa    = r_ins.dst;
        w_wd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_a_raw = i_req.coef_a;
                    n_b_raw = i_req.coef_b;
                    n_m     = i_req.modulus;
                    n_n     = i_req.term_index;
                    n_small = (i_req.term_index < W_INDEX'(3));
                    n_exp   = EXP_BITS'(w_e);
                    n_pc    = '0;
                    if (i_req.modulus == '0) begin
                        // no reduction possible, answer zero
                        n_out   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_ins = w_ins;
                unique case (w_ins.op)
                    OP_BRS: begin
                        n_pc = r_small ? w_ins.tgt : r_pc + 1'b1;
                    end
                    OP_BIT: begin
                        n_pc = r_exp[0] ? r_pc + 1'b1 : w_ins.tgt;
                    end
                    OP_NEXT: begin
                        // stop once no set exponent bit remains
                        n_exp = w_exp_shr;
                        n_pc  = (w_exp_shr != '0) ? w_ins.tgt : r_pc + 1'b1;
                    end
                    OP_MUL: begin
                        n_pc    = r_pc + 1'b1;
                        n_state = S_MSTART;
                    end
                    default: begin
                        n_pc    = r_pc + 1'b1;
                        n_state = S_EXEC;
                    end
                endcase
            end
            S_EXEC: begin
                n_state = S_FETCH;
                unique case (r_ins.op)
                    OP_LD0: begin
                        w_we = 1'b1;
                        w_wd = '0;
                    end
                    OP_LD1: begin
                        w_we = 1'b1;
                        w_wd = W_DATA'(r_m != W_DATA'(1));
                    end
                    OP_LDA: begin
                        w_we = 1'b1;
                        w_wd = r_a_raw;
                    end
                    OP_LDB: begin
                        w_we = 1'b1;
                        w_wd = r_b_raw;
                    end
                    OP_ADD: begin
                        w_we = 1'b1;
                        w_wd = w_addm[W_DATA-1:0];
                    end
                    OP_SUB: begin
                        w_we = 1'b1;
                        w_wd = w_subm;
                    end
                    OP_OUT: begin
                        n_out   = r_rdx;
                        n_state = S_OUT;
                    end
                    default: begin
                        w_we = 1'b0;
                    end
                endcase
            end
            S_MSTART: begin
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (w_mrsp.done) begin
                    w_we    = 1'b1;
                    w_wd    = w_mrsp.prod;
                    n_state = S_FETCH;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
        r_ins   <= n_ins;
        r_a_raw <= n_a_raw;
        r_b_raw <= n_b_raw;
        r_m     <= n_m;
        r_n     <= n_n;
        r_exp   <= n_exp;
        r_small <= n_small;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (r_state == S_FETCH) begin
            r_rdx <= r_mem[w_ax];
            r_rdy <= r_mem[w_ins.sy];
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = (r_state == S_OUT);
    assign o_rsp.term_value = r_out;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request and result sides active together");

    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_m != '0) |-> (o_rsp.term_value < r_m))
        else $error("result not reduced below modulus");

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mrsp.done |-> (r_state == S_MWAIT))
        else $error("multiplier finished outside the wait step");

    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MSTART) |=> (r_state == S_MWAIT))
        else $error("multiplier start not followed by wait");
`endif

endmodule

// ===== dv/tb_modular_recurrence_matrix_power.sv =====
// testbench for the modular recurrence matrix power block: directed and random terms
module tb_modular_recurrence_matrix_power;
    timeunit 1ns;
    timeprecision 1ps;
    import mrmp_pkg::*;

    logic i_clk;
    logic i_rst_n;

    mrmp_in_if  req_if();
    mrmp_out_if rsp_if();

    modular_recurrence_matrix_power dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    t_word  term_q[$];
    int     fail_cnt = 0;
    longint cycle_cnt = 0;
    bit     quiet;      // no idling in the closing part of the run
    int     rsp_stall = 0;

    // 2x2 matrix product mod m
    typedef logic [63:0] t_m4[4];

    function automatic void mat_mul(input t_m4 p, input t_m4 q, input logic [63:0] m,
                                    output t_m4 r);
        r[0] = ((p[0] * q[0]) % m + (p[1] * q[2]) % m) % m;
        r[1] = ((p[0] * q[1]) % m + (p[1] * q[3]) % m) % m;
        r[2] = ((p[2] * q[0]) % m + (p[3] * q[2]) % m) % m;
        r[3] = ((p[2] * q[1]) % m + (p[3] * q[3]) % m) % m;
    endfunction

    // expected term s_n mod m
    function automatic t_word recurrence_term(t_word ca, t_word cb, logic [31:0] n,
                                              t_word md);
        logic [63:0] m, a, b, a2, s1, s2, diff, e;
        t_m4 base, acc, tmp;
        if (md == 0) return '0;
        m  = md;
        a  = ca % m;
        b  = cb % m;
        a2 = (a * a) % m;
        s1 = (a + a) % m;
        s2 = ((a2 + a2) % m + (b + b) % m) % m;
        if (n == 0) return t_word'(2 % m);
        if (n == 1) return t_word'(s1);
        if (n == 2) return t_word'(s2);
        diff = (b + (m - a2) % m) % m;
        base[0] = s1; base[1] = 1 % m; base[2] = diff; base[3] = 0;
        acc[0] = 1 % m; acc[1] = 0; acc[2] = 0; acc[3] = 1 % m;
        e = n - 2;
        for (int i = 0; i < EXP_BITS_DEF; i++) begin
            if (e[i]) begin
                mat_mul(acc, base, m, tmp);
                acc = tmp;
            end
            mat_mul(base, base, m, tmp);
            base = tmp;
        end
        return t_word'(((s2 * acc[0]) % m + (s1 * acc[2]) % m) % m);
    endfunction

    // one request transfer, with optional idle burst before it
    task automatic send_term(t_word ca, t_word cb, logic [31:0] n, t_word md);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        req_if.valid      <= 1'b1;
        req_if.coef_a     <= ca;
        req_if.coef_b     <= cb;
        req_if.term_index <= n;
        req_if.modulus    <= md;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        term_q.push_back(recurrence_term(ca, cb, n, md));
        @(negedge i_clk);
        req_if.valid <= 1'b0;
    endtask

    // result side: random stall bursts, compare each transfer
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (term_q.size() == 0) begin
                $display("%0t: unexpected term_value %0d", $time, rsp_if.term_value);
                fail_cnt++;
            end else begin
                if (rsp_if.term_value !== term_q[0]) begin
                    $display("%0t: term_value expected %0d actual %0d",
                             $time, term_q[0], rsp_if.term_value);
                    fail_cnt++;
                end
                void'(term_q.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_stall <= $urandom_range(1, 19);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // watchdog for a run of about 300 items
    always @(posedge i_clk) begin
        if (cycle_cnt > 64'd30000000) begin
            $display("modular_recurrence_matrix_power regression: fail");
            $finish;
        end
    end

    function automatic t_word rand_word();
        return t_word'($urandom);
    endfunction

    task automatic wait_drained();
        while (term_q.size() != 0) @(negedge i_clk);
    endtask

    // index and modulus extremes, small indexes, zero and one modulus
    task automatic test_directed();
        send_term('0, '0, 32'd1, 31'd1);
        send_term('1, '1, 32'd1, '1);
        send_term('1, '1, 32'd2, '1);
        send_term('1, '1, 32'hFFFF_FFFF, '1);
        send_term(31'd3, 31'd5, 32'd3, 31'd1000);
        send_term(31'd3, 31'd5, 32'd10, 31'd1000);
        send_term(31'd7, 31'd9, 32'd20, 31'd0);
        send_term(31'd7, 31'd9, 32'd20, 31'd1);
        send_term(31'd7, 31'd9, 32'd2, 31'd2);
        send_term(31'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h7FFF_FFFF);
        send_term(31'h2AAA_AAAA, 31'h5555_5555, 32'h5555_5555, 31'h7FFF_FFFE);
        // b smaller than a^2 forces the negative difference
        send_term(31'd100, 31'd1, 32'd7, 31'd97);
        send_term(31'd0, 31'd0, 32'd0, 31'd13);
        send_term(31'd1, 31'd0, 32'h8000_0000, 31'd65537);
        send_term('1, '0, 32'd4, 31'd3);
    endtask

    // sender holds until all results are in
    task automatic test_drain_pause();
        send_term(rand_word(), rand_word(), $urandom, rand_word());
        wait_drained();
        send_term(rand_word(), rand_word(), 32'd5, rand_word());
    endtask

    // random items, half with short indexes, the rest 16-bit or full width
    task automatic test_random(int cnt);
        logic [31:0] n;
        t_word md;
        for (int i = 0; i < cnt; i++) begin
            case ($urandom_range(0, 3))
                0: n = $urandom_range(1, 4);
                1: n = $urandom_range(1, 300);
                2: n = $urandom & 32'h0000_FFFF;
                default: n = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0: md = t_word'($urandom_range(0, 3));
                1: md = t_word'($urandom_range(1, 1000));
                default: md = rand_word();
            endcase
            send_term(rand_word(), rand_word(), n, md);
        end
    endtask

    initial begin
        quiet = 0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.coef_a = '0;
        req_if.coef_b = '0;
        req_if.term_index = '0;
        req_if.modulus = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_drain_pause();
        test_random(230);
        quiet = 1;
        test_random(45);

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("modular_recurrence_matrix_power regression: pass");
        else
            $display("modular_recurrence_matrix_power regression: fail");
        $finish;
    end
endmodule
